// ===== rtl/mpfb_pkg.sv =====
// ----------------------------------------------------------------------------
// mpfb_pkg: shared types and constants
// Geometry, command codes and state encodings for the page framebuffer.
// ----------------------------------------------------------------------------
package mpfb_pkg;
	localparam int COLUMNS = 128;
	localparam int ROWS = 64;
	localparam int PAGES = (ROWS + 7) / 8;
	localparam int STORE_SIZE = COLUMNS * PAGES;
	localparam int AW = $clog2(STORE_SIZE);
	localparam int LANES = 8;

	typedef enum logic [1:0] {
		CMD_FILL = 2'd0,
		CMD_PIXEL = 2'd1,
		CMD_IMAGE = 2'd2,
		CMD_READ = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_RD,
		ST_WR,
		ST_RESULT
	} state_t;

	// one lane's pixel update request
	typedef struct packed {
		logic en;
		logic [AW-1:0] addr;
		logic [2:0] bitpos;
		logic on;
	} lane_req_t;
endpackage

// ===== rtl/mono_page_framebuffer_blit_top.sv =====
// ----------------------------------------------------------------------------
// mono_page_framebuffer_blit_top: 128x64 page framebuffer
// Fill, pixel, image byte blit and byte read on a single-port store.
// ----------------------------------------------------------------------------
// One item at a time. After reset a clearing pass over all 1024 bytes zeroes
// the store before any item is taken; a fill runs the same pass with its colour.
// For a pixel or an image byte, eight lanes clip the pixels in parallel (a pixel
// uses lane 0 only), then every lane's column byte is read in turn on the one
// store port and written back unless that lane is clipped.
// A read passes through the read and write states, then raises out_valid, holds
// it until the result is taken, and takes the input again in the cycle after that.
module mono_page_framebuffer_blit_top
	import mpfb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] command,
	input  logic [7:0] x,
	input  logic [7:0] y,
	input  logic       color,
	input  logic [7:0] width,
	input  logic [7:0] height,
	input  logic [7:0] image_bits,
	input  logic       start_req,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] read_data
);
	logic [7:0] mem [STORE_SIZE];
	state_t state_q, state_d;
	logic [AW:0] clr_q;
	logic [7:0] fill_q;
	logic [7:0] org_col_q, org_row_q, bw_q, bh_q, cur_col_q, cur_row_q;
	lane_req_t reqs [LANES];
	lane_req_t job_d [LANES];
	lane_req_t job_q [LANES];
	logic [3:0] lane_q;
	logic [7:0] rd_q;
	logic rd_zero_q;
	logic [7:0] res_q;

	logic [7:0] e_oc, e_or, e_bw, e_bh, e_cc, e_cr, b_row;
	logic active;
	logic [8:0] nxt;
	logic acc;
	logic cur_en;
	logic [AW-1:0] cur_addr;

	assign acc = in_valid && in_ready;

	always_comb begin
		e_oc = start_req ? x : org_col_q;
		e_or = start_req ? y : org_row_q;
		e_bw = start_req ? width : bw_q;
		e_bh = start_req ? height : bh_q;
		e_cc = start_req ? 8'd0 : cur_col_q;
		e_cr = start_req ? 8'd0 : cur_row_q;
		b_row = e_or + e_cr;
		active = (e_bw != 8'd0) && (e_cr < e_bh);
		nxt = {1'b0, e_cc} + 9'd8;
	end

	for (genvar g = 0; g < LANES; g++) begin : g_lane
		mpfb_lane u_lane (
			.k(3'(g)), .origin_col(e_oc), .row(b_row), .cursor_col(e_cc),
			.blit_width(e_bw), .active(active), .bit_val(image_bits[g]),
			.req(reqs[g])
		);
	end

	assign cur_en = (lane_q < 4'(LANES)) && job_q[lane_q[2:0]].en;
	assign cur_addr = job_q[lane_q[2:0]].addr;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					unique case (cmd_t'(command))
						CMD_FILL: state_d = ST_CLEAR;
						CMD_PIXEL: state_d = ST_RD;
						CMD_IMAGE: state_d = ST_RD;
						CMD_READ: state_d = ST_RD;
					endcase
				end
			end
			ST_CLEAR: if (clr_q == (AW+1)'(STORE_SIZE - 1)) state_d = ST_IDLE;
			ST_RD: state_d = ST_WR;
			ST_WR: begin
				if (rd_zero_q) state_d = ST_RESULT;
				else if (lane_q >= 4'(LANES - 1)) state_d = ST_IDLE;
				else state_d = ST_RD;
			end
			ST_RESULT: if (out_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == ST_IDLE);
		out_valid = (state_q == ST_RESULT);
		read_data = res_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			fill_q <= 8'h00;
			org_col_q <= '0; org_row_q <= '0; bw_q <= '0; bh_q <= '0;
			cur_col_q <= '0; cur_row_q <= '0;
			lane_q <= '0;
			rd_zero_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
			if (acc) begin
				clr_q <= '0;
				fill_q <= color ? 8'hFF : 8'h00;
				rd_zero_q <= (cmd_t'(command) == CMD_READ);
				if (cmd_t'(command) == CMD_PIXEL || cmd_t'(command) == CMD_IMAGE)
					lane_q <= '0;
				else
					lane_q <= 4'(LANES);
				if (cmd_t'(command) == CMD_IMAGE) begin
					org_col_q <= e_oc; org_row_q <= e_or;
					bw_q <= e_bw; bh_q <= e_bh;
					if (active) begin
						if (nxt >= {1'b0, e_bw}) begin
							cur_col_q <= '0;
							cur_row_q <= e_cr + 8'd1;
						end else begin
							cur_col_q <= nxt[7:0];
							cur_row_q <= e_cr;
						end
					end else begin
						cur_col_q <= e_cc; cur_row_q <= e_cr;
					end
				end
			end else if (state_q == ST_WR && !rd_zero_q) begin
				lane_q <= lane_q + 4'd1;
			end
		end
	end

	// job capture; pixel and read commands use lane 0 only
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			job_d[i] = reqs[i];
			if (cmd_t'(command) != CMD_IMAGE) job_d[i].en = 1'b0;
		end
		if (cmd_t'(command) == CMD_PIXEL || cmd_t'(command) == CMD_READ) begin
			job_d[0].en = (32'(x) < COLUMNS) && ((cmd_t'(command) == CMD_PIXEL)
				? (32'(y) < ROWS) : (32'(y >> 3) < PAGES));
			job_d[0].addr = AW'(16'(x) + 16'(y >> 3) * 16'(COLUMNS));
			job_d[0].bitpos = y[2:0];
			job_d[0].on = color;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			for (int i = 0; i < LANES; i++)
				job_q[i] <= job_d[i];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_CLEAR) mem[clr_q[AW-1:0]] <= fill_q;
		if (state_q == ST_RD) rd_q <= mem[cur_addr];
		if (state_q == ST_WR && !rd_zero_q && cur_en) begin
			if (job_q[lane_q[2:0]].on)
				mem[cur_addr] <= rd_q | (8'd1 << job_q[lane_q[2:0]].bitpos);
			else
				mem[cur_addr] <= rd_q & ~(8'd1 << job_q[lane_q[2:0]].bitpos);
		end
		if (state_q == ST_WR && rd_zero_q)
			res_q <= job_q[0].en ? rd_q : 8'h00;
	end

	ap_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(read_data))
		else $error("result changed while stalled");
	ap_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !in_ready)
		else $error("ready while busy");
	ap_lane_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WR && !rd_zero_q) |-> (lane_q < 4'(LANES)))
		else $error("lane index out of range");
endmodule

// ===== rtl/mpfb_lane.sv =====
// ----------------------------------------------------------------------------
// mpfb_lane: one pixel lane
// Clips one image pixel and forms its store address and bit position.
// ----------------------------------------------------------------------------
module mpfb_lane
	import mpfb_pkg::*;
(
	input  logic [2:0]  k,
	input  logic [7:0]  origin_col,
	input  logic [7:0]  row,
	input  logic [7:0]  cursor_col,
	input  logic [7:0]  blit_width,
	input  logic        active,
	input  logic        bit_val,
	output lane_req_t   req
);
	logic [8:0] off;
	logic [7:0] col;
	logic [15:0] idx;

	always_comb begin
		off = {1'b0, cursor_col} + {6'd0, k};
		col = origin_col + off[7:0];
		idx = 16'(col) + 16'(row >> 3) * 16'(COLUMNS);
		req.en = active && (off < {1'b0, blit_width}) && (32'(col) < COLUMNS)
			&& (32'(row) < ROWS);
		req.addr = idx[AW-1:0];
		req.bitpos = row[2:0];
		req.on = bit_val;
	end
endmodule

// ===== tb/mono_page_framebuffer_blit_checker.sv =====
// ----------------------------------------------------------------------------
// mono_page_framebuffer_blit_checker: framebuffer predictor and read checker
// Follows every input transfer, keeps its own copy of the page store and the
// blit cursor, queues the byte each read should return and compares it with
// every output transfer.
// ----------------------------------------------------------------------------
module mono_page_framebuffer_blit_checker
	import mpfb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [1:0] command,
	input  logic [7:0] x,
	input  logic [7:0] y,
	input  logic       color,
	input  logic [7:0] width,
	input  logic [7:0] height,
	input  logic [7:0] image_bits,
	input  logic       start_req,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [7:0] read_data,
	output int         fail_count,
	output int         pending_reads
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [7:0] page_store [STORE_SIZE];
	logic [7:0] org_col, org_row, img_w, img_h, cur_col, cur_row;
	logic [7:0] read_bytes_q [$];

	assign pending_reads = read_bytes_q.size();

	task automatic plot(input int col, input int row, input logic on);
		int idx;
		if (col >= COLUMNS || row >= ROWS)
			return;
		idx = col + (row >> 3) * COLUMNS;
		page_store[idx][row & 7] = on;
	endtask

	task automatic blit_image_byte(input logic [7:0] bits);
		int off;
		logic [7:0] row;
		if (img_w == 0 || cur_row >= img_h)
			return;
		row = org_row + cur_row;
		for (int k = 0; k < 8; k++) begin
			off = cur_col + k;
			if (off >= img_w)
				break;
			plot((org_col + off) & 8'hFF, row, bits[k]);
		end
		if (int'(cur_col) + 8 >= img_w) begin
			cur_col = 0;
			cur_row = cur_row + 1;
		end else begin
			cur_col = cur_col + 8;
		end
	endtask

	function automatic logic [7:0] store_byte(input logic [7:0] col, input logic [7:0] row);
		if (col >= COLUMNS || (row >> 3) >= PAGES)
			return 8'h00;
		return page_store[col + (row >> 3) * COLUMNS];
	endfunction

	initial begin
		fail_count = 0;
		foreach (page_store[i]) page_store[i] = 8'h00;
		{org_col, org_row, img_w, img_h, cur_col, cur_row} = '0;
	end

	always @(posedge clk) begin
		logic [7:0] want;
		if (arst_n && in_valid && in_ready) begin
			case (cmd_t'(command))
				CMD_FILL:
					foreach (page_store[i]) page_store[i] = color ? 8'hFF : 8'h00;
				CMD_PIXEL:
					plot(x, y, color);
				CMD_IMAGE: begin
					if (start_req) begin
						org_col = x;
						org_row = y;
						img_w = width;
						img_h = height;
						cur_col = 0;
						cur_row = 0;
					end
					blit_image_byte(image_bits);
				end
				CMD_READ:
					read_bytes_q.push_back(store_byte(x, y));
			endcase
		end
		if (arst_n && out_valid && out_ready) begin
			if (read_bytes_q.size() == 0) begin
				$display("%0t: unexpected read_data transfer, expected none, actual %02h",
					$time, read_data);
				fail_count++;
			end else begin
				want = read_bytes_q.pop_front();
				if (read_data !== want) begin
					$display("%0t: read_data mismatch, expected %02h, actual %02h",
						$time, want, read_data);
					fail_count++;
				end
			end
		end
	end
endmodule

// ===== tb/mono_page_framebuffer_blit_top_test.sv =====
// ----------------------------------------------------------------------------
// mono_page_framebuffer_blit_top_test: page framebuffer testbench
// Drives directed and random fill, pixel, blit and read commands under
// varying idle and stall patterns; the checker compares every read byte.
// ----------------------------------------------------------------------------
module mono_page_framebuffer_blit_top_test;
	import mpfb_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 3_000_000;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [1:0] command;
	logic [7:0] x, y, width, height, image_bits;
	logic       color, start_req;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] read_data;
	int         fail_count;
	int         pending_reads;
	int         idle_pct;
	int         stall_pct;
	int         cycles;
	int         sent_items;

	mono_page_framebuffer_blit_top i_dut (.*);

	mono_page_framebuffer_blit_checker i_checker (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// receiver stalls
	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= stall_pct);

	// valid stays high from one transfer into the next unless the sender idles
	task automatic send(input cmd_t c, input int px, input int py,
		input int pc, input int pw, input int ph,
		input int pb, input int ps);
		if ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
			while ($urandom_range(99) < idle_pct) @(negedge clk);
		end
		command <= c;
		x <= 8'(px);
		y <= 8'(py);
		color <= 1'(pc);
		width <= 8'(pw);
		height <= 8'(ph);
		image_bits <= 8'(pb);
		start_req <= 1'(ps);
		in_valid <= 1'b1;
		sent_items++;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_random_read();
		send(CMD_READ, $urandom_range(135), $urandom_range(71), 0, 0, 0, 0, 0);
	endtask

	// blit: a start byte then n+1 more image bytes (n: image bytes, at most 40), with reads mixed in
	task automatic send_blit_run();
		int w, h;
		int n;
		w = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(1, 24);
		h = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(1, 10);
		n = ((w + 7) / 8) * h;
		if (n > 40) n = 40;
		send(CMD_IMAGE, $urandom_range(255),
			$urandom_range(3) == 0 ? $urandom_range(255) : $urandom_range(70),
			$urandom_range(1), w, h, $urandom_range(255), 1);
		for (int i = 1; i < n + 2; i++) begin
			if ($urandom_range(3) == 0) send_random_read();
			send(CMD_IMAGE, $urandom_range(255), $urandom_range(255), $urandom_range(1),
				$urandom_range(255), $urandom_range(255), $urandom_range(255), 0);
		end
	endtask

	task automatic run_phase(input int idle, input int stall, input int items);
		int first;
		idle_pct = idle;
		stall_pct = stall;
		first = sent_items;
		while (sent_items - first < items) begin
			case ($urandom_range(19))
				0: send(CMD_FILL, $urandom_range(255), $urandom_range(255),
					$urandom_range(1), $urandom_range(255), $urandom_range(255),
					$urandom_range(255), $urandom_range(1));
				1, 2, 3, 4: send(CMD_PIXEL, $urandom_range(3) == 0 ? $urandom_range(255) :
					$urandom_range(127), $urandom_range(3) == 0 ? $urandom_range(255) :
					$urandom_range(63), $urandom_range(1), $urandom_range(255),
					$urandom_range(255), $urandom_range(255), $urandom_range(1));
				5, 6, 7, 8, 9, 10: send_blit_run();
				11: send(CMD_IMAGE, $urandom_range(255), $urandom_range(255),
					$urandom_range(1), $urandom_range(255), $urandom_range(255),
					$urandom_range(255), $urandom_range(1));
				default: send_random_read();
			endcase
		end
	endtask

	initial begin
		cycles = 0;
		sent_items = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		command = CMD_FILL;
		{x, y, width, height, image_bits} = '0;
		color = 1'b0;
		start_req = 1'b0;
		out_ready = 1'b1;
		idle_pct = 0;
		stall_pct = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: cleared store, image byte before any blit, pixel clipping
		send(CMD_READ, 0, 0, 0, 0, 0, 0, 0);
		send(CMD_IMAGE, 0, 0, 1, 0, 0, 255, 0);
		send(CMD_PIXEL, 127, 63, 1, 0, 0, 0, 0);
		send(CMD_PIXEL, 128, 0, 1, 0, 0, 0, 0);
		send(CMD_PIXEL, 0, 64, 1, 0, 0, 0, 0);
		send(CMD_PIXEL, 255, 255, 1, 0, 0, 0, 0);
		send(CMD_READ, 127, 63, 0, 0, 0, 0, 0);
		send(CMD_READ, 128, 0, 0, 0, 0, 0, 0);
		send(CMD_READ, 0, 64, 0, 0, 0, 0, 0);
		// blit wrapping past column 255 and row 255, width not a multiple of 8
		send(CMD_IMAGE, 250, 254, 0, 13, 3, 'hA5, 1);
		send(CMD_IMAGE, 0, 0, 0, 0, 0, 'h5A, 0);
		send(CMD_IMAGE, 0, 0, 0, 0, 0, 'hFF, 0);
		send(CMD_READ, 0, 0, 0, 0, 0, 0, 0);
		send(CMD_READ, 4, 0, 0, 0, 0, 0, 0);
		// zero-width blit does nothing
		send(CMD_IMAGE, 3, 3, 0, 0, 255, 'hFF, 1);
		send(CMD_READ, 3, 0, 0, 0, 0, 0, 0);
		send(CMD_FILL, 0, 0, 1, 0, 0, 0, 0);
		send(CMD_IMAGE, 120, 56, 0, 255, 255, 0, 1);
		send(CMD_READ, 120, 63, 0, 0, 0, 0, 0);
		send(CMD_READ, 255, 255, 0, 0, 0, 0, 0);
		send(CMD_FILL, 0, 0, 0, 0, 0, 0, 0);
		send(CMD_READ, 64, 32, 0, 0, 0, 0, 0);

		run_phase(0, 0, 430);
		// hold until every read has returned
		in_valid <= 1'b0;
		while (pending_reads != 0) @(negedge clk);
		run_phase(76, 0, 430);
		run_phase(0, 76, 430);
		run_phase(36, 36, 430);

		idle_pct = 0;
		in_valid <= 1'b0;
		while (pending_reads != 0) @(negedge clk);
		repeat (1100) @(negedge clk);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
